// ===== hw/rtl/hrza_pkg.sv =====
package hrza_pkg;

	localparam int TimeBitsDef = 32;

	localparam int BpmW = 8;
	localparam int RateW = 12;
	localparam int DelayW = 32;
	localparam int HoldW = 16;
	localparam int StampW = 32;
	localparam int CfgIndexW = 3;
	localparam int CfgDataW = 32;

	typedef enum logic [1:0] {
		ZONE_CALM = 2'd0,
		ZONE_ELEVATED = 2'd1,
		ZONE_CRITICAL = 2'd2
	} zone_t;

	localparam logic [1:0] CMD_SAMPLE = 2'd0;
	localparam logic [1:0] CMD_CLR_WARN = 2'd1;
	localparam logic [1:0] CMD_CLR_DANGER = 2'd2;

	localparam logic [CfgIndexW-1:0] REG_SAFE_LOW = 3'd0;
	localparam logic [CfgIndexW-1:0] REG_SAFE_HIGH = 3'd1;
	localparam logic [CfgIndexW-1:0] REG_DANGER_BELOW = 3'd2;
	localparam logic [CfgIndexW-1:0] REG_DANGER_ABOVE = 3'd3;
	localparam logic [CfgIndexW-1:0] REG_WARNING_DELAY = 3'd4;
	localparam logic [CfgIndexW-1:0] REG_DANGER_DELAY = 3'd5;
	localparam logic [CfgIndexW-1:0] REG_WEAR_HOLD = 3'd6;

	// Fixed warning bands in Q8.4 bpm.
	localparam logic [RateW-1:0] WARN_LOW_MIN = 12'd640;
	localparam logic [RateW-1:0] WARN_LOW_MAX = 12'd784;
	localparam logic [RateW-1:0] WARN_HIGH_MIN = 12'd1616;
	localparam logic [RateW-1:0] WARN_HIGH_MAX = 12'd1760;

	typedef struct packed {
		logic [BpmW-1:0] safe_low;
		logic [BpmW-1:0] safe_high;
		logic [BpmW-1:0] danger_below;
		logic [BpmW-1:0] danger_above;
		logic [DelayW-1:0] warning_delay;
		logic [DelayW-1:0] danger_delay;
		logic [HoldW-1:0] wear_hold;
	} cfg_t;

	localparam cfg_t CFG_RESET = '{
		safe_low: 8'd50,
		safe_high: 8'd100,
		danger_below: 8'd39,
		danger_above: 8'd111,
		warning_delay: 32'd20000,
		danger_delay: 32'd5000,
		wear_hold: 16'd3000
	};

endpackage

// ===== hw/rtl/hrza_sample_if.sv =====
interface hrza_sample_if;
	logic valid;
	logic ready;
	logic [1:0] cmd;
	logic [11:0] bpm_x16;
	logic wearing;
	logic [31:0] now_ms;

	modport source (output valid, output cmd, output bpm_x16, output wearing, output now_ms,
		input ready);
	modport sink (input valid, input cmd, input bpm_x16, input wearing, input now_ms,
		output ready);
endinterface

// ===== hw/rtl/hrza_result_if.sv =====
interface hrza_result_if;
	logic valid;
	logic ready;
	logic [1:0] zone;
	logic warning_alert;
	logic danger_alert;
	logic [31:0] time_in_zone_ms;

	modport source (output valid, output zone, output warning_alert, output danger_alert,
		output time_in_zone_ms, input ready);
	modport sink (input valid, input zone, input warning_alert, input danger_alert,
		input time_in_zone_ms, output ready);
endinterface

// ===== hw/rtl/hrza_classify.sv =====
module hrza_classify
	import hrza_pkg::*;
(
	input cfg_t cfg,
	input logic [RateW-1:0] bpm_x16,
	input logic worn,
	output zone_t zone
);

	logic [RateW-1:0] safe_lo;
	logic [RateW-1:0] safe_hi;
	logic [RateW-1:0] dng_lo;
	logic [RateW-1:0] dng_hi;
	logic in_safe;
	logic in_danger;
	logic in_warn;

	assign safe_lo = {cfg.safe_low, 4'h0};
	assign safe_hi = {cfg.safe_high, 4'h0};
	assign dng_lo = {cfg.danger_below, 4'h0};
	assign dng_hi = {cfg.danger_above, 4'h0};

	assign in_safe = (bpm_x16 >= safe_lo) && (bpm_x16 <= safe_hi);
	assign in_danger = (bpm_x16 <= dng_lo) || (bpm_x16 >= dng_hi);
	assign in_warn = ((bpm_x16 >= WARN_LOW_MIN) && (bpm_x16 <= WARN_LOW_MAX)) ||
		((bpm_x16 >= WARN_HIGH_MIN) && (bpm_x16 <= WARN_HIGH_MAX));

	always_comb begin
		if (!worn) begin
			zone = ZONE_CALM;
		end else if (bpm_x16 == '0) begin
			zone = ZONE_CRITICAL;
		end else if (in_safe) begin
			zone = ZONE_CALM;
		end else if (in_danger) begin
			zone = ZONE_CRITICAL;
		end else if (in_warn) begin
			zone = ZONE_ELEVATED;
		end else begin
			zone = ZONE_CALM;
		end
	end

endmodule

// ===== hw/rtl/heart_rate_zone_alarm.sv =====
// Channel  Role    Payload
// sample   sink    cmd, bpm_x16, wearing, now_ms
// result   source  zone, warning_alert, danger_alert, time_in_zone_ms
// cfg      write   cfg_wen, cfg_index, cfg_data
//
// One word is accepted per cycle unless a stalled result holds the input register.
// The input register and the result register each hold one word, so a new word is
// taken while a finished result waits; a stalled result holds the input register.
// Reset clears the zone state, the latches and both valid flags and loads the
// configuration defaults.
module heart_rate_zone_alarm
	import hrza_pkg::*;
#(
	parameter int TIME_BITS = TimeBitsDef
) (
	input logic clk,
	input logic arst_n,
	hrza_sample_if.sink sample,
	hrza_result_if.source result,
	input logic cfg_wen,
	input logic [CfgIndexW-1:0] cfg_index,
	input logic [CfgDataW-1:0] cfg_data
);

	localparam int XW = TIME_BITS + 32;

	cfg_t cfg_q;

	logic valid_s1;
	logic [1:0] cmd_s1;
	logic [RateW-1:0] bpm_s1;
	logic wearing_s1;
	logic [StampW-1:0] now_s1;

	zone_t zone_q;
	logic [TIME_BITS-1:0] entry_q;
	logic [TIME_BITS-1:0] last_worn_q;
	logic warn_q;
	logic danger_q;

	logic valid_s2;
	zone_t zone_s2;
	logic warn_s2;
	logic danger_s2;
	logic [StampW-1:0] elapsed_s2;

	logic advance;
	logic is_sample;
	logic [XW-1:0] now_x;
	logic [TIME_BITS-1:0] now_t;
	logic [TIME_BITS-1:0] hold_gap;
	logic worn_eff;
	zone_t zone_cls;
	logic zone_chg;
	zone_t zone_d;
	logic [TIME_BITS-1:0] entry_d;
	logic [TIME_BITS-1:0] elapsed;
	logic [XW-1:0] elapsed_x;
	logic warn_d;
	logic danger_d;

	assign advance = valid_s1 && (!valid_s2 || result.ready);
	assign sample.ready = !valid_s1 || advance;
	assign is_sample = (cmd_s1 == CMD_SAMPLE);

	assign now_x = {{TIME_BITS{1'b0}}, now_s1};
	assign now_t = now_x[TIME_BITS-1:0];

	assign hold_gap = now_t - last_worn_q;
	assign worn_eff = wearing_s1 ||
		({32'b0, hold_gap} < {{(TIME_BITS + 16){1'b0}}, cfg_q.wear_hold});

	hrza_classify u_classify (
		.cfg(cfg_q),
		.bpm_x16(bpm_s1),
		.worn(worn_eff),
		.zone(zone_cls)
	);

	assign zone_chg = is_sample && (zone_cls != zone_q);
	assign zone_d = zone_chg ? zone_cls : zone_q;
	assign entry_d = zone_chg ? now_t : entry_q;
	assign elapsed = now_t - entry_d;
	assign elapsed_x = {32'b0, elapsed};

	always_comb begin
		warn_d = zone_chg ? 1'b0 : warn_q;
		danger_d = zone_chg ? 1'b0 : danger_q;
		if (is_sample && (zone_d == ZONE_ELEVATED) &&
			(elapsed_x >= {{TIME_BITS{1'b0}}, cfg_q.warning_delay})) begin
			warn_d = 1'b1;
		end
		if (is_sample && (zone_d == ZONE_CRITICAL) &&
			(elapsed_x >= {{TIME_BITS{1'b0}}, cfg_q.danger_delay})) begin
			danger_d = 1'b1;
		end
		if (cmd_s1 == CMD_CLR_WARN) begin
			warn_d = 1'b0;
		end
		if (cmd_s1 == CMD_CLR_DANGER) begin
			danger_d = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= CFG_RESET;
		end else if (cfg_wen) begin
			case (cfg_index)
				REG_SAFE_LOW: cfg_q.safe_low <= cfg_data[BpmW-1:0];
				REG_SAFE_HIGH: cfg_q.safe_high <= cfg_data[BpmW-1:0];
				REG_DANGER_BELOW: cfg_q.danger_below <= cfg_data[BpmW-1:0];
				REG_DANGER_ABOVE: cfg_q.danger_above <= cfg_data[BpmW-1:0];
				REG_WARNING_DELAY: cfg_q.warning_delay <= cfg_data[DelayW-1:0];
				REG_DANGER_DELAY: cfg_q.danger_delay <= cfg_data[DelayW-1:0];
				REG_WEAR_HOLD: cfg_q.wear_hold <= cfg_data[HoldW-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (sample.ready) begin
			valid_s1 <= sample.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (sample.valid && sample.ready) begin
			cmd_s1 <= sample.cmd;
			bpm_s1 <= sample.bpm_x16;
			wearing_s1 <= sample.wearing;
			now_s1 <= sample.now_ms;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			zone_q <= ZONE_CALM;
			entry_q <= '0;
			last_worn_q <= '0;
			warn_q <= 1'b0;
			danger_q <= 1'b0;
		end else if (advance) begin
			zone_q <= zone_d;
			entry_q <= entry_d;
			if (is_sample && wearing_s1) begin
				last_worn_q <= now_t;
			end
			warn_q <= warn_d;
			danger_q <= danger_d;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= 1'b1;
		end else if (result.ready) begin
			valid_s2 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			zone_s2 <= zone_d;
			warn_s2 <= warn_d;
			danger_s2 <= danger_d;
			elapsed_s2 <= elapsed_x[StampW-1:0];
		end
	end

	assign result.valid = valid_s2;
	assign result.zone = zone_s2;
	assign result.warning_alert = warn_s2;
	assign result.danger_alert = danger_s2;
	assign result.time_in_zone_ms = elapsed_s2;

`ifndef SYNTHESIS
	a_warn_in_zone: assert property (@(posedge clk) disable iff (!arst_n)
		warn_q |-> (zone_q == ZONE_ELEVATED))
		else $error("Warning latch set outside the warning zone.");

	a_danger_in_zone: assert property (@(posedge clk) disable iff (!arst_n)
		danger_q |-> (zone_q == ZONE_CRITICAL))
		else $error("Danger latch set outside the danger zone.");

	a_entry_on_change: assert property (@(posedge clk) disable iff (!arst_n)
		(advance && zone_chg) |=> (entry_q == $past(now_t)))
		else $error("Zone change did not restart the zone timer.");

	a_hold_stalled_word: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_s1 && !advance) |=> valid_s1)
		else $error("Input word dropped while the result was stalled.");

	a_state_only_on_advance: assert property (@(posedge clk) disable iff (!arst_n)
		!advance |=> ($stable(zone_q) && $stable(entry_q)))
		else $error("Zone state changed without a word being processed.");
`endif

endmodule

// ===== tb/sv/heart_rate_zone_alarm_test.sv =====
`timescale 1ns / 100ps

module heart_rate_zone_alarm_test
	import hrza_pkg::*;
;

	localparam logic [1:0] CMD_UNUSED = 2'd3;

	localparam int WarnLowMinBpm = 40;
	localparam int WarnLowMaxBpm = 49;
	localparam int WarnHighMinBpm = 101;
	localparam int WarnHighMaxBpm = 110;

	localparam int HoldOffCycles = 80;
	localparam int DrainLimit = 5000;

	typedef struct packed {
		logic [1:0] cmd;
		logic [RateW-1:0] bpm_x16;
		logic wearing;
		logic [StampW-1:0] now_ms;
	} hr_sample_t;

	typedef struct packed {
		zone_t zone;
		logic warning_alert;
		logic danger_alert;
		logic [StampW-1:0] time_in_zone_ms;
	} alarm_status_t;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_wen;
	logic [CfgIndexW-1:0] cfg_index;
	logic [CfgDataW-1:0] cfg_data;

	hrza_sample_if sample_bus ();
	hrza_result_if result_bus ();

	heart_rate_zone_alarm i_dut (
		.clk(clk),
		.arst_n(arst_n),
		.sample(sample_bus),
		.result(result_bus),
		.cfg_wen(cfg_wen),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Predicted state of the alarm and its registers.
	cfg_t alarm_cfg = CFG_RESET;
	zone_t zone_now = ZONE_CALM;
	logic [StampW-1:0] zone_start_ms = '0;
	logic [StampW-1:0] last_worn_ms = '0;
	logic warn_latched = 1'b0;
	logic danger_latched = 1'b0;

	alarm_status_t alarm_expect_q[$];

	int error_count = 0;
	int words_sent = 0;
	int results_checked = 0;
	int configs_applied = 0;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	logic result_hold = 1'b0;
	logic [StampW-1:0] stamp_ms = '0;
	event hold_off_start;

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	initial begin
		#2000000;
		$display("Timeout: the run did not finish in time.");
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	task automatic report_mismatch(input string msg);
		if (error_count < 40) begin
			$display("ERROR at %0t: %s", $time, msg);
		end
		error_count++;
	endtask

	function automatic zone_t classify_rate(input logic [RateW-1:0] rate, input logic wearing,
		input logic [StampW-1:0] now_ms);
		logic worn;
		logic [StampW-1:0] since_worn;
		int r;
		worn = wearing;
		r = int'(rate);
		since_worn = now_ms - last_worn_ms;
		if (wearing) begin
			last_worn_ms = now_ms;
		end else if (since_worn < {16'd0, alarm_cfg.wear_hold}) begin
			worn = 1'b1;
		end
		if (!worn) return ZONE_CALM;
		if (r == 0) return ZONE_CRITICAL;
		if (r >= int'(alarm_cfg.safe_low) * 16 && r <= int'(alarm_cfg.safe_high) * 16)
			return ZONE_CALM;
		if (r <= int'(alarm_cfg.danger_below) * 16 || r >= int'(alarm_cfg.danger_above) * 16)
			return ZONE_CRITICAL;
		if ((r >= WarnLowMinBpm * 16 && r <= WarnLowMaxBpm * 16) ||
			(r >= WarnHighMinBpm * 16 && r <= WarnHighMaxBpm * 16))
			return ZONE_ELEVATED;
		return ZONE_CALM;
	endfunction

	function automatic alarm_status_t predict_alarm(input hr_sample_t w);
		zone_t next_zone;
		logic [StampW-1:0] in_zone_ms;
		alarm_status_t r;
		case (w.cmd)
			CMD_SAMPLE: begin
				next_zone = classify_rate(w.bpm_x16, w.wearing, w.now_ms);
				if (next_zone != zone_now) begin
					zone_now = next_zone;
					zone_start_ms = w.now_ms;
					warn_latched = 1'b0;
					danger_latched = 1'b0;
				end
				in_zone_ms = w.now_ms - zone_start_ms;
				if (zone_now == ZONE_ELEVATED && in_zone_ms >= alarm_cfg.warning_delay)
					warn_latched = 1'b1;
				if (zone_now == ZONE_CRITICAL && in_zone_ms >= alarm_cfg.danger_delay)
					danger_latched = 1'b1;
			end
			CMD_CLR_WARN: warn_latched = 1'b0;
			CMD_CLR_DANGER: danger_latched = 1'b0;
			default: ;
		endcase
		r.zone = zone_now;
		r.warning_alert = warn_latched;
		r.danger_alert = danger_latched;
		r.time_in_zone_ms = w.now_ms - zone_start_ms;
		return r;
	endfunction

	task automatic send_word(input hr_sample_t w);
		while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
			sample_bus.valid <= 1'b0;
			@(posedge clk);
		end
		sample_bus.valid <= 1'b1;
		sample_bus.cmd <= w.cmd;
		sample_bus.bpm_x16 <= w.bpm_x16;
		sample_bus.wearing <= w.wearing;
		sample_bus.now_ms <= w.now_ms;
		do begin
			@(posedge clk);
		end while (!sample_bus.ready);
		alarm_expect_q.push_back(predict_alarm(w));
		words_sent++;
	endtask

	task automatic sample_at(input logic [1:0] cmd, input logic [RateW-1:0] rate,
		input logic wearing, input logic [StampW-1:0] now_ms);
		hr_sample_t w;
		w.cmd = cmd;
		w.bpm_x16 = rate;
		w.wearing = wearing;
		w.now_ms = now_ms;
		send_word(w);
	endtask

	// Lowers valid and waits until every predicted result has been seen or the drain limit is reached.
	task automatic wait_for_results();
		int waited;
		waited = 0;
		sample_bus.valid <= 1'b0;
		do begin
			@(posedge clk);
			waited++;
		end while (alarm_expect_q.size() != 0 && waited < DrainLimit);
		if (alarm_expect_q.size() != 0) begin
			report_mismatch($sformatf("%0d results never arrived", alarm_expect_q.size()));
			alarm_expect_q.delete();
		end
		repeat (4) @(posedge clk);
	endtask

	task automatic write_reg(input logic [CfgIndexW-1:0] index, input logic [CfgDataW-1:0] data);
		cfg_wen <= 1'b1;
		cfg_index <= index;
		cfg_data <= data;
		@(posedge clk);
	endtask

	task automatic apply_config(input cfg_t c);
		write_reg(REG_SAFE_LOW, CfgDataW'(c.safe_low));
		write_reg(REG_SAFE_HIGH, CfgDataW'(c.safe_high));
		write_reg(REG_DANGER_BELOW, CfgDataW'(c.danger_below));
		write_reg(REG_DANGER_ABOVE, CfgDataW'(c.danger_above));
		write_reg(REG_WARNING_DELAY, CfgDataW'(c.warning_delay));
		write_reg(REG_DANGER_DELAY, CfgDataW'(c.danger_delay));
		write_reg(REG_WEAR_HOLD, CfgDataW'(c.wear_hold));
		cfg_wen <= 1'b0;
		alarm_cfg = c;
		configs_applied++;
	endtask

	function automatic logic [DelayW-1:0] random_delay();
		int pick;
		pick = $urandom_range(99);
		if (pick < 10) return '0;
		if (pick < 15) return DelayW'($urandom);
		return DelayW'($urandom_range(15000));
	endfunction

	function automatic cfg_t random_config();
		cfg_t c;
		if ($urandom_range(3) == 0) begin
			c.safe_low = BpmW'($urandom);
			c.safe_high = BpmW'($urandom);
			c.danger_below = BpmW'($urandom);
			c.danger_above = BpmW'($urandom);
		end else begin
			c.safe_low = BpmW'($urandom_range(60, 40));
			c.safe_high = BpmW'($urandom_range(110, 85));
			c.danger_below = BpmW'($urandom_range(48, 30));
			c.danger_above = BpmW'($urandom_range(125, 100));
		end
		c.warning_delay = random_delay();
		c.danger_delay = random_delay();
		c.wear_hold = ($urandom_range(4) == 0) ? HoldW'($urandom) : HoldW'($urandom_range(6000));
		return c;
	endfunction

	// The heart rate drifts slowly so that zones last long enough for alerts to latch,
	// with jumps, dropouts, lost wear and odd timestamps mixed in.
	task automatic run_random(input int n_words);
		hr_sample_t w;
		int rate;
		int pick;
		logic worn;
		rate = 75 * 16;
		worn = 1'b1;
		for (int i = 0; i < n_words; i++) begin
			pick = $urandom_range(99);
			if (pick < 6) begin
				rate = $urandom_range(4095);
			end else if (pick < 10) begin
				rate = 0;
			end else if (pick < 20) begin
				rate = $urandom_range(150 * 16, 25 * 16);
			end else begin
				rate = rate + int'($urandom_range(48)) - 24;
				if (rate < 0) rate = 0;
				if (rate > 4095) rate = 4095;
			end
			if (worn && $urandom_range(99) < 5) worn = 1'b0;
			else if (!worn && $urandom_range(99) < 15) worn = 1'b1;
			pick = $urandom_range(99);
			if (pick < 70) stamp_ms = stamp_ms + $urandom_range(1500);
			else if (pick < 90) stamp_ms = stamp_ms + $urandom_range(8000, 1500);
			else if (pick < 96) stamp_ms = stamp_ms + $urandom_range(70000);
			else if (pick < 98) stamp_ms = $urandom;
			else stamp_ms = 32'hFFFF_FFFF - $urandom_range(3000);
			w.now_ms = stamp_ms;
			w.bpm_x16 = RateW'(rate);
			w.wearing = worn;
			pick = $urandom_range(99);
			if (pick < 84) begin
				w.cmd = CMD_SAMPLE;
			end else begin
				if (pick < 91) w.cmd = CMD_CLR_WARN;
				else if (pick < 98) w.cmd = CMD_CLR_DANGER;
				else w.cmd = CMD_UNUSED;
				w.bpm_x16 = RateW'($urandom);
				w.wearing = 1'($urandom);
			end
			send_word(w);
		end
	endtask

	task automatic test_zone_classification();
		sample_at(CMD_SAMPLE, 75 * 16, 1'b1, 32'd1000);
		sample_at(CMD_SAMPLE, 0, 1'b1, 32'd1500);
		sample_at(CMD_SAMPLE, 12'hFFF, 1'b1, 32'd2000);
		sample_at(CMD_SAMPLE, 45 * 16, 1'b1, 32'd2500);
		sample_at(CMD_SAMPLE, 105 * 16, 1'b1, 32'd3000);
		sample_at(CMD_SAMPLE, 12'd792, 1'b1, 32'd3500);
		sample_at(CMD_SAMPLE, 12'd632, 1'b1, 32'd3600);
		sample_at(CMD_SAMPLE, 45 * 16, 1'b0, 32'd5000);
		sample_at(CMD_SAMPLE, 45 * 16, 1'b0, 32'd6600);
		sample_at(CMD_SAMPLE, 0, 1'b0, 32'd7000);
		wait_for_results();
	endtask

	task automatic test_alert_latching();
		sample_at(CMD_SAMPLE, 0, 1'b1, 32'd10000);
		sample_at(CMD_SAMPLE, 0, 1'b1, 32'd15000);
		sample_at(CMD_CLR_DANGER, 12'hFFF, 1'b0, 32'd15100);
		sample_at(CMD_UNUSED, 12'hABC, 1'b1, 32'd15200);
		sample_at(CMD_SAMPLE, 105 * 16, 1'b1, 32'd16000);
		sample_at(CMD_SAMPLE, 105 * 16, 1'b1, 32'd36000);
		sample_at(CMD_CLR_WARN, 0, 1'b1, 32'd36100);
		sample_at(CMD_SAMPLE, 105 * 16, 1'b1, 32'hFFFF_FFF0);
		sample_at(CMD_SAMPLE, 105 * 16, 1'b1, 32'h0000_0010);
		wait_for_results();
	endtask

	task automatic test_config_extremes();
		apply_config('0);
		sample_at(CMD_SAMPLE, 12'd16, 1'b1, 32'd100);
		sample_at(CMD_SAMPLE, 12'd2000, 1'b0, 32'd101);
		wait_for_results();
		apply_config('1);
		sample_at(CMD_SAMPLE, 12'hFFF, 1'b1, 32'd1);
		sample_at(CMD_SAMPLE, 12'hFFF, 1'b1, 32'd0);
		sample_at(CMD_SAMPLE, 100 * 16, 1'b0, 32'h0000_FFFE);
		sample_at(CMD_SAMPLE, 0, 1'b0, 32'hFFFF_FFFF);
		wait_for_results();
	endtask

	task automatic test_backpressure();
		send_idle_pct = 0;
		recv_stall_pct <= 0;
		apply_config(CFG_RESET);
		-> hold_off_start;
		run_random(40);
		wait_for_results();
	endtask

	task automatic test_random_traffic();
		int sender_gap_pct[4] = '{0, 62, 0, 17};
		int receiver_gap_pct[4] = '{0, 0, 62, 17};
		for (int m = 0; m < 4; m++) begin
			send_idle_pct = sender_gap_pct[m];
			recv_stall_pct <= receiver_gap_pct[m];
			for (int k = 0; k < 2; k++) begin
				apply_config(random_config());
				run_random(110);
				wait_for_results();
			end
		end
		send_idle_pct = 0;
		recv_stall_pct <= 0;
	endtask

	always @(posedge clk) begin
		result_bus.ready <= !result_hold && ($urandom_range(99) >= recv_stall_pct);
	end

	// A long receiver hold-off, counted here so that the sender keeps pushing meanwhile.
	always begin
		@(hold_off_start);
		result_hold <= 1'b1;
		repeat (HoldOffCycles) @(posedge clk);
		result_hold <= 1'b0;
	end

	always @(posedge clk) begin : check_results
		alarm_status_t want;
		if (arst_n && result_bus.valid && result_bus.ready) begin
			if (alarm_expect_q.size() == 0) begin
				report_mismatch("result word with no sample outstanding");
			end else begin
				want = alarm_expect_q.pop_front();
				results_checked++;
				if (result_bus.zone !== want.zone ||
					result_bus.warning_alert !== want.warning_alert ||
					result_bus.danger_alert !== want.danger_alert ||
					result_bus.time_in_zone_ms !== want.time_in_zone_ms) begin
					report_mismatch($sformatf(
						"got zone %0d warn %b danger %b ms %0d, expected %0d %b %b %0d",
						result_bus.zone, result_bus.warning_alert, result_bus.danger_alert,
						result_bus.time_in_zone_ms, want.zone, want.warning_alert,
						want.danger_alert, want.time_in_zone_ms));
				end
			end
		end
	end

	initial begin
		arst_n = 1'b0;
		cfg_wen = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		sample_bus.valid = 1'b0;
		sample_bus.cmd = CMD_SAMPLE;
		sample_bus.bpm_x16 = '0;
		sample_bus.wearing = 1'b0;
		sample_bus.now_ms = '0;
		result_bus.ready = 1'b0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_zone_classification();
		test_alert_latching();
		test_config_extremes();
		test_backpressure();
		test_random_traffic();
		wait_for_results();

		$display("Sent %0d sample words and checked %0d results under %0d register settings,",
			words_sent, results_checked, configs_applied);
		$display("with free flow, sender gaps, receiver stalls, both, and a long receiver hold-off.");
		if (error_count == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule

// ===== heart_rate_zone_alarm.f =====
hw/rtl/hrza_pkg.sv
hw/rtl/hrza_sample_if.sv
hw/rtl/hrza_result_if.sv
hw/rtl/hrza_classify.sv
hw/rtl/heart_rate_zone_alarm.sv
tb/sv/heart_rate_zone_alarm_test.sv
